// ===== sv/pss_pkg.sv =====
package pss_pkg;

    // default table size and idle priority
    localparam int SLOTS_DEF     = 16;
    localparam int IDLE_PRIO_DEF = 255;

    // field widths
    localparam int REQ_W    = 3;
    localparam int PRIO_W   = 8;
    localparam int EXP_W    = 64;
    localparam int NOW_W    = 63;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // request codes
    localparam logic [REQ_W-1:0] REQ_SET       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR_ALL = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TICK      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LOOKUP    = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

    // expiry marker for an entry that never times out
    localparam logic [EXP_W-1:0] NEVER_EXPIRES = {EXP_W{1'b1}};

endpackage

// ===== sv/priority_source_selector_top.sv =====
// priority source selector: one item in, one result out
// clear-all and unknown requests go from accept straight to the apply state, which
// registers the result once the output is free; set, clear, tick and lookup first
// walk every slot (scan, drain, apply); a new item is accepted only back in idle
// reset (aresetn low, synchronous): table empty, winner at IDLE_PRIO, no result pending
module priority_source_selector_top #(
    parameter int SLOTS     = pss_pkg::SLOTS_DEF,
    parameter int IDLE_PRIO = pss_pkg::IDLE_PRIO_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pss_pkg::REQ_W-1:0]     s_req_type,
    input  logic [pss_pkg::PRIO_W-1:0]    s_prio,
    input  logic signed [pss_pkg::EXP_W-1:0] s_expiry_ms,
    input  logic [pss_pkg::NOW_W-1:0]     s_now_ms,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pss_pkg::PRIO_W-1:0]    m_winner_prio,
    output logic                          m_hit,
    output logic signed [pss_pkg::EXP_W-1:0] m_found_expiry,
    output logic [pss_pkg::STATUS_W-1:0]  m_status,
    output logic [pss_pkg::COUNT_W-1:0]   m_active_count
);
    import pss_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOTS - 1);
    localparam logic [PRIO_W-1:0] IDLE_P    = PRIO_W'(IDLE_PRIO);
    localparam logic [PRIO_W-1:0] MAX_P     = {PRIO_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_APPLY
    } state_t;

    state_t state_reg;

    // latched item
    logic [REQ_W-1:0]  req_type_reg;
    logic [PRIO_W-1:0] req_prio_reg;
    logic [EXP_W-1:0]  req_exp_reg;
    logic [NOW_W-1:0]  req_now_reg;

    // table
    logic [SLOTS-1:0]  slot_valid_reg;
    logic [PRIO_W-1:0] slot_prio_mem [SLOTS];
    logic [EXP_W-1:0]  slot_expiry_mem [SLOTS];
    logic [PRIO_W-1:0] prio_rd_reg;
    logic [EXP_W-1:0]  exp_rd_reg;
    logic [COUNT_W-1:0] active_reg;
    logic [PRIO_W-1:0] winner_reg;

    // slot walk
    logic [IDX_W-1:0]  scan_idx_reg;
    logic              eval_vld_reg;
    logic [IDX_W-1:0]  eval_idx_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  found_idx_reg;
    logic [EXP_W-1:0]  found_exp_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic [PRIO_W-1:0] min_reg;

    // result register
    logic                m_valid_reg;
    logic [PRIO_W-1:0]   m_winner_reg;
    logic                m_hit_reg;
    logic [EXP_W-1:0]    m_found_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // per-slot evaluation of the slot read last cycle
    logic ev_v, ev_match, ev_expired, ev_min;
    always_comb begin
        ev_v       = slot_valid_reg[eval_idx_reg];
        ev_match   = ev_v && (prio_rd_reg == req_prio_reg);
        ev_expired = ev_v && (exp_rd_reg != NEVER_EXPIRES)
                     && ($signed(exp_rd_reg) <= $signed({1'b0, req_now_reg}));
        ev_min     = 1'b0;
        case (req_type_reg)
            REQ_CLEAR: ev_min = ev_v && (prio_rd_reg != req_prio_reg)
                                && (prio_rd_reg < min_reg);
            REQ_TICK:  ev_min = ev_v && !ev_expired && (prio_rd_reg < min_reg);
            default:   ev_min = 1'b0;
        endcase
    end

    // outcome of the request once the walk, if any, is done
    logic [PRIO_W-1:0]   win_next;
    logic [COUNT_W-1:0]  count_next;
    logic [SLOTS-1:0]    valid_next;
    logic                hit_next;
    logic [EXP_W-1:0]    found_next;
    logic [STATUS_W-1:0] status_next;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_wa;
    always_comb begin
        win_next    = winner_reg;
        count_next  = active_reg;
        valid_next  = slot_valid_reg;
        hit_next    = 1'b0;
        found_next  = NEVER_EXPIRES;
        status_next = STAT_OK;
        mem_we      = 1'b0;
        mem_wa      = found_reg ? found_idx_reg : free_idx_reg;
        case (req_type_reg)
            REQ_SET: begin
                if (found_reg || free_found_reg) begin
                    mem_we = 1'b1;
                    if (!found_reg) begin
                        valid_next[free_idx_reg] = 1'b1;
                        count_next = active_reg + COUNT_W'(1);
                    end
                    if (req_prio_reg < winner_reg) win_next = req_prio_reg;
                end else begin
                    status_next = STAT_FULL;
                end
            end
            REQ_CLEAR: begin
                if (found_reg) begin
                    valid_next[found_idx_reg] = 1'b0;
                    count_next = active_reg - COUNT_W'(1);
                    if (winner_reg == req_prio_reg)
                        win_next = (count_next == '0) ? IDLE_P : min_reg;
                end else begin
                    status_next = STAT_NOT_FOUND;
                end
            end
            REQ_CLEAR_ALL: begin
                valid_next = '0;
                count_next = '0;
                win_next   = IDLE_P;
            end
            REQ_TICK: begin
                win_next = min_reg;
            end
            REQ_LOOKUP: begin
                hit_next = found_reg;
                if (req_prio_reg == IDLE_P) begin
                    found_next = NEVER_EXPIRES;
                end else if (found_reg) begin
                    found_next = found_exp_reg;
                end else begin
                    status_next = STAT_NOT_FOUND;
                end
            end
            default: begin
                status_next = STAT_OK;
            end
        endcase
    end

    // sequencer, table state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            slot_valid_reg <= '0;
            active_reg     <= '0;
            winner_reg     <= IDLE_P;
            eval_vld_reg   <= 1'b0;
        end else begin
            eval_vld_reg <= (state_reg == ST_SCAN);
            if (m_ready && state_reg != ST_APPLY) m_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        req_type_reg   <= s_req_type;
                        req_prio_reg   <= s_prio;
                        req_exp_reg    <= s_expiry_ms;
                        req_now_reg    <= s_now_ms;
                        scan_idx_reg   <= '0;
                        found_reg      <= 1'b0;
                        free_found_reg <= 1'b0;
                        min_reg        <= (s_req_type == REQ_TICK) ? IDLE_P : MAX_P;
                        if (s_req_type == REQ_SET || s_req_type == REQ_CLEAR ||
                            s_req_type == REQ_TICK || s_req_type == REQ_LOOKUP) begin
                            state_reg <= ST_SCAN;
                        end else begin
                            state_reg <= ST_APPLY;
                        end
                    end
                end
                ST_SCAN: begin
                    eval_idx_reg <= scan_idx_reg;
                    if (scan_idx_reg == LAST_IDX) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_APPLY;
                end
                ST_APPLY: begin
                    if (out_free) begin
                        slot_valid_reg <= valid_next;
                        active_reg     <= count_next;
                        winner_reg     <= win_next;
                        m_valid_reg    <= 1'b1;
                        m_winner_reg   <= win_next;
                        m_hit_reg      <= hit_next;
                        m_found_reg    <= found_next;
                        m_status_reg   <= status_next;
                        m_count_reg    <= count_next;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // evaluate one slot per cycle
            if (eval_vld_reg) begin
                if (ev_match && !found_reg) begin
                    found_reg     <= 1'b1;
                    found_idx_reg <= eval_idx_reg;
                    found_exp_reg <= exp_rd_reg;
                end
                if (!ev_v && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= eval_idx_reg;
                end
                if (ev_min) min_reg <= prio_rd_reg;
                if (req_type_reg == REQ_TICK && ev_expired) begin
                    slot_valid_reg[eval_idx_reg] <= 1'b0;
                    active_reg <= active_reg - COUNT_W'(1);
                end
            end
        end
    end

    // table memory: one write port, one registered read at the walk index
    always_ff @(posedge aclk) begin
        if (state_reg == ST_APPLY && out_free && mem_we) begin
            slot_prio_mem[mem_wa]   <= req_prio_reg;
            slot_expiry_mem[mem_wa] <= req_exp_reg;
        end
        prio_rd_reg <= slot_prio_mem[scan_idx_reg];
        exp_rd_reg  <= slot_expiry_mem[scan_idx_reg];
    end

    assign m_valid        = m_valid_reg;
    assign m_winner_prio  = m_winner_reg;
    assign m_hit          = m_hit_reg;
    assign m_found_expiry = m_found_reg;
    assign m_status       = m_status_reg;
    assign m_active_count = m_count_reg;

    // count never exceeds the table size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg <= COUNT_W'(SLOTS))
        else $error("active count above table size");

    // count tracks the valid bits
    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg == COUNT_W'($countones(slot_valid_reg)))
        else $error("active count out of step with valid bits");

    // empty table between items means idle winner
    a_empty_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && active_reg == '0) |-> winner_reg == IDLE_P)
        else $error("winner not idle on empty table");

    // an accepted item always starts work
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg != ST_IDLE)
        else $error("accepted item did not start");

endmodule
